// ===== rtl/sma_pkg.sv =====
// Shared constants, types and helpers for the simple moving average core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package sma_pkg;

   localparam int WINDOW_MAX   = 16;
   localparam int WINDOW_RESET = 10;
   localparam int SAMPLE_W     = 16;
   localparam int CFG_W        = 5;
   localparam int HELD_W       = 5;
   localparam int AVG_W        = 24;
   localparam int FRAC_W       = 8;
   localparam int PTR_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W        = SAMPLE_W + PTR_W;
   localparam int DIVIDEND_W   = SUM_W + FRAC_W;
   localparam int STEP_W       = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic load_out;
      logic cfg_write;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

   function automatic logic [CNT_W-1:0] clamp_window(input logic [CFG_W-1:0] raw);
      int v;
      v = int'(raw);
      if (v == 0) begin
         v = 1;
      end
      if (v > WINDOW_MAX) begin
         v = WINDOW_MAX;
      end
      return CNT_W'(v);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/simple_moving_average_core.sv =====
// Top level of the simple moving average core: joins the controller and datapath.
// Depends on sma_pkg, sma_ctrl and sma_dp.
//
//   Channel  Direction  Handshake            Word
//   req      in         req_valid/req_stall  req_sample_value
//   rsp      out        rsp_valid/rsp_stall  rsp_average_q8, rsp_samples_held
//   csr      in         csr_valid/csr_ready  csr_window_length
//
// From acceptance each word goes through these steps: the ring is read at acceptance, an
// update step sets sum and count, the divide state forms the quotient one bit per step
// and a final step loads the result register. A new word is taken only after that load,
// so a word can be accepted even while the last result still waits.
// Reset restores a window of ten and empties the window; a window write sets the clamped new length and empties it too.
// A stalled result holds the divider output until the register ahead of it frees.
`timescale 1ns / 1ps
`default_nettype none
module simple_moving_average_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [sma_pkg::SAMPLE_W-1:0]  req_sample_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [sma_pkg::AVG_W-1:0]     rsp_average_q8,
   output logic      [sma_pkg::HELD_W-1:0]    rsp_samples_held,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sma_pkg::CFG_W-1:0]     csr_window_length
);

   sma_pkg::cmd_type    cmd;
   sma_pkg::status_type status;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sma_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample_value  (req_sample_value),
      .csr_window_length (csr_window_length),
      .rsp_average_q8    (rsp_average_q8),
      .rsp_samples_held  (rsp_samples_held)
   );

endmodule
`default_nettype wire

// ===== rtl/sma_ctrl.sv =====
// Controller state machine of the moving average core: sequences capture, update,
// the bit-serial division and the result hand-off. Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sma_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  sma_pkg::status_type     status,
   output sma_pkg::cmd_type        cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.cfg_write = csr_valid && (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/sma_dp.sv =====
// Datapath of the moving average core: sample ring, running sum, fill count and a
// restoring divider that yields one quotient bit per cycle. Depends on sma_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sma_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  sma_pkg::cmd_type                   cmd,
   output sma_pkg::status_type                status,
   input  wire logic [sma_pkg::SAMPLE_W-1:0]  req_sample_value,
   input  wire logic [sma_pkg::CFG_W-1:0]     csr_window_length,
   output logic      [sma_pkg::AVG_W-1:0]     rsp_average_q8,
   output logic      [sma_pkg::HELD_W-1:0]    rsp_samples_held
);

   logic [sma_pkg::SAMPLE_W-1:0]   ring_mem [sma_pkg::WINDOW_MAX];
   logic [sma_pkg::SAMPLE_W-1:0]   sample_ff;
   logic [sma_pkg::SAMPLE_W-1:0]   old_ff;
   logic [sma_pkg::CNT_W-1:0]      window_ff;
   logic [sma_pkg::CNT_W-1:0]      window_in;
   logic [sma_pkg::PTR_W-1:0]      wp_ff;
   logic [sma_pkg::PTR_W-1:0]      wp_in;
   logic [sma_pkg::CNT_W-1:0]      fill_ff;
   logic [sma_pkg::CNT_W-1:0]      fill_in;
   logic [sma_pkg::SUM_W-1:0]      sum_ff;
   logic [sma_pkg::SUM_W-1:0]      sum_in;
   logic [sma_pkg::SUM_W-1:0]      sum_new;
   logic [sma_pkg::CNT_W-1:0]      fill_new;
   logic [sma_pkg::CNT_W-1:0]      wp_inc;
   logic [sma_pkg::STEP_W-1:0]     step_ff;
   logic [sma_pkg::STEP_W-1:0]     step_in;
   logic [sma_pkg::DIVIDEND_W-1:0] quo_ff;
   logic [sma_pkg::DIVIDEND_W-1:0] quo_in;
   logic [sma_pkg::CNT_W-1:0]      rem_ff;
   logic [sma_pkg::CNT_W-1:0]      rem_in;
   logic [sma_pkg::CNT_W-1:0]      div_ff;
   logic [sma_pkg::CNT_W:0]        partial;
   logic [sma_pkg::CNT_W:0]        trial;
   logic [sma_pkg::AVG_W-1:0]      avg_ff;
   logic [sma_pkg::HELD_W-1:0]     held_ff;

   assign rsp_average_q8   = avg_ff;
   assign rsp_samples_held = held_ff;
   assign status.div_last  = (step_ff == sma_pkg::STEP_W'(sma_pkg::DIVIDEND_W - 1));

   // Once the window is full the oldest sample leaves the sum as the new one enters.
   always_comb begin
      if (fill_ff >= window_ff) begin
         fill_new = window_ff;
         sum_new  = sum_ff - sma_pkg::SUM_W'(old_ff) + sma_pkg::SUM_W'(sample_ff);
      end else begin
         fill_new = fill_ff + 1'b1;
         sum_new  = sum_ff + sma_pkg::SUM_W'(sample_ff);
      end
      wp_inc = sma_pkg::CNT_W'(wp_ff) + 1'b1;
   end

   assign partial = {rem_ff, quo_ff[sma_pkg::DIVIDEND_W-1]};
   assign trial   = partial - {1'b0, div_ff};

   always_comb begin
      window_in = window_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      step_in   = step_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (cmd.cfg_write) begin
         window_in = sma_pkg::clamp_window(csr_window_length);
         wp_in     = '0;
         fill_in   = '0;
         sum_in    = '0;
      end else if (cmd.update) begin
         fill_in = fill_new;
         sum_in  = sum_new;
         wp_in   = (wp_inc >= window_ff) ? '0 : wp_inc[sma_pkg::PTR_W-1:0];
         step_in = '0;
         quo_in  = {sum_new, {sma_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + 1'b1;
         if (partial >= {1'b0, div_ff}) begin
            rem_in = trial[sma_pkg::CNT_W-1:0];
            quo_in = {quo_ff[sma_pkg::DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = partial[sma_pkg::CNT_W-1:0];
            quo_in = {quo_ff[sma_pkg::DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= sma_pkg::clamp_window(sma_pkg::CFG_W'(sma_pkg::WINDOW_RESET));
         wp_ff     <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
         step_ff   <= '0;
      end else begin
         window_ff <= window_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.capture) begin
         sample_ff <= req_sample_value;
         old_ff    <= ring_mem[wp_ff];
      end
      if (cmd.update) begin
         ring_mem[wp_ff] <= sample_ff;
         div_ff          <= fill_new;
      end
      if (cmd.load_out) begin
         avg_ff  <= quo_ff[sma_pkg::AVG_W-1:0];
         held_ff <= sma_pkg::HELD_W'(div_ff);
      end
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for simple_moving_average_core: directed table, then random phases.
// Depends on sma_pkg and the core; expected means come from the typed table words or a boxcar predictor kept here.
`timescale 1ns / 1ps
module tb;

   typedef struct packed {
      logic [sma_pkg::AVG_W-1:0]  average_q8;
      logic [sma_pkg::HELD_W-1:0] samples_held;
   } mean_word_type;

   typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [15:0]   value;
      logic          typed;
      mean_word_type word;
   } stim_row_type;

   localparam int RANDOM_ITEMS = 1850;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [sma_pkg::SAMPLE_W-1:0] req_sample_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [sma_pkg::AVG_W-1:0] rsp_average_q8;
   logic [sma_pkg::HELD_W-1:0] rsp_samples_held;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sma_pkg::CFG_W-1:0] csr_window_length = '0;

   logic [sma_pkg::SAMPLE_W-1:0] held_ring [sma_pkg::WINDOW_MAX];
   logic [3:0]  ring_wr;
   logic [4:0]  held_count;
   logic [19:0] window_sum;
   logic [4:0]  window_len;

   mean_word_type pending_means [$];
   int  error_count = 0;
   int  samples_sent = 0;
   bit  steady_phase = 1'b0;
   int  stall_run = 0;

   stim_row_type directed_rows [26] = '{
      '{ROW_SAMPLE, 16'd65535, 1'b1, '{24'd16776960, 5'd1}},
      '{ROW_SAMPLE, 16'd0,     1'b1, '{24'd8388480,  5'd2}},
      '{ROW_SAMPLE, 16'd1,     1'b0, '{24'd0,        5'd0}},
      '{ROW_WINDOW, 16'd0,     1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd0,     1'b1, '{24'd0,        5'd1}},
      '{ROW_SAMPLE, 16'd65535, 1'b1, '{24'd16776960, 5'd1}},
      '{ROW_SAMPLE, 16'd12345, 1'b1, '{24'd3160320,  5'd1}},
      '{ROW_WINDOW, 16'd31,    1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd65535, 1'b1, '{24'd16776960, 5'd1}},
      '{ROW_SAMPLE, 16'd65535, 1'b1, '{24'd16776960, 5'd2}},
      '{ROW_SAMPLE, 16'd43690, 1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd21845, 1'b0, '{24'd0,        5'd0}},
      '{ROW_WINDOW, 16'd16,    1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd0,     1'b1, '{24'd0,        5'd1}},
      '{ROW_SAMPLE, 16'd3,     1'b1, '{24'd384,      5'd2}},
      '{ROW_WINDOW, 16'd17,    1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd65535, 1'b1, '{24'd16776960, 5'd1}},
      '{ROW_WINDOW, 16'd1,     1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd7,     1'b1, '{24'd1792,     5'd1}},
      '{ROW_SAMPLE, 16'd9,     1'b1, '{24'd2304,     5'd1}},
      '{ROW_WINDOW, 16'd2,     1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd1,     1'b1, '{24'd256,      5'd1}},
      '{ROW_SAMPLE, 16'd2,     1'b1, '{24'd384,      5'd2}},
      '{ROW_SAMPLE, 16'd4,     1'b1, '{24'd768,      5'd2}},
      '{ROW_WINDOW, 16'd15,    1'b0, '{24'd0,        5'd0}},
      '{ROW_SAMPLE, 16'd100,   1'b1, '{24'd25600,    5'd1}}
   };

   simple_moving_average_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_value  (req_sample_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average_q8    (rsp_average_q8),
      .rsp_samples_held  (rsp_samples_held),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 3000000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void clear_window(input logic [4:0] raw);
      window_len = (raw == 5'd0) ? 5'd1 :
                   (raw > 5'(sma_pkg::WINDOW_MAX)) ? 5'(sma_pkg::WINDOW_MAX) : raw;
      for (int i = 0; i < sma_pkg::WINDOW_MAX; i++) begin
         held_ring[i] = '0;
      end
      ring_wr    = '0;
      held_count = '0;
      window_sum = '0;
   endfunction

   function automatic mean_word_type boxcar_mean(input logic [15:0] sample);
      logic [3:0]    slot;
      logic [4:0]    next_slot;
      logic [27:0]   scaled;
      mean_word_type word;
      slot = ring_wr;
      if (5'(slot) >= window_len) begin
         slot = '0;
      end
      if (held_count >= window_len) begin
         held_count = window_len;
         window_sum = window_sum - 20'(held_ring[slot]);
      end else begin
         held_count = held_count + 5'd1;
      end
      held_ring[slot] = sample;
      window_sum = window_sum + 20'(sample);
      next_slot = 5'(slot) + 5'd1;
      if (next_slot >= window_len) begin
         next_slot = '0;
      end
      ring_wr = next_slot[3:0];
      scaled = {window_sum, 8'd0};
      word.average_q8   = 24'(scaled / 28'(held_count));
      word.samples_held = held_count;
      return word;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 16);
      end
      return $urandom_range(30, 100);
   endfunction

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_sample(input logic [15:0] sample, input logic typed,
                              input mean_word_type typed_word);
      mean_word_type predicted;
      int gap;
      req_valid <= 1'b1;
      req_sample_value <= sample;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = boxcar_mean(sample);
      pending_means.push_back(typed ? typed_word : predicted);
      samples_sent++;
      gap = steady_phase ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [4:0] raw);
      drain_results();
      csr_valid <= 1'b1;
      csr_window_length <= raw;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      clear_window(raw);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if (rsp_stall || steady_phase) begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 24);
      end else begin
         rsp_stall <= 1'b1;
         stall_run <= idle_length();
      end
   end

   always @(posedge clock) begin
      mean_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_means.size() == 0) begin
            flag_error($sformatf("unexpected result word avg=%0d held=%0d",
                                 rsp_average_q8, rsp_samples_held));
         end else begin
            want = pending_means.pop_front();
            if (rsp_average_q8 !== want.average_q8) begin
               flag_error($sformatf("average_q8 got %0d want %0d",
                                    rsp_average_q8, want.average_q8));
            end
            if (rsp_samples_held !== want.samples_held) begin
               flag_error($sformatf("samples_held got %0d want %0d",
                                    rsp_samples_held, want.samples_held));
            end
         end
      end
   end

   initial begin
      int count;
      int r;
      logic [4:0]  raw;
      logic [15:0] sample;
      clear_window(5'(sma_pkg::WINDOW_RESET));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WINDOW) begin
            write_window(directed_rows[i].value[4:0]);
         end else begin
            send_sample(directed_rows[i].value, directed_rows[i].typed,
                        directed_rows[i].word);
         end
      end

      while (samples_sent < RANDOM_ITEMS) begin
         r = $urandom_range(0, 9);
         case (r)
            0: raw = 5'd0;
            1: raw = 5'd1;
            2: raw = 5'd16;
            3: raw = 5'd31;
            default: raw = 5'($urandom_range(0, 31));
         endcase
         write_window(raw);
         steady_phase = ($urandom_range(0, 3) == 0);
         count = $urandom_range(1, 48);
         repeat (count) begin
            r = $urandom_range(0, 9);
            case (r)
               0: sample = 16'd0;
               1: sample = 16'hFFFF;
               2: sample = 16'($urandom_range(0, 15));
               default: sample = 16'($urandom_range(0, 65535));
            endcase
            send_sample(sample, 1'b0, '0);
         end
         steady_phase = 1'b0;
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_means.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== simple_moving_average_core.f =====
rtl/sma_pkg.sv
rtl/sma_ctrl.sv
rtl/sma_dp.sv
rtl/simple_moving_average_core.sv
tb/sv/tb.sv
